### src/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants for the gpio port register bank.
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam int NUM_PORTS     = 8;
  localparam int PINS_PER_PORT = 16;

  // address widths of the port words
  localparam int PORT_AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // input and output field widths
  localparam int OP_W    = 2;
  localparam int PORT_W  = 3;
  localparam int PIN_W   = 4;
  localparam int MODE_W  = 2;
  localparam int PULL_W  = 2;
  localparam int SPEED_W = 2;
  localparam int ALT_W   = 4;
  localparam int LEVEL_W = 2;
  localparam int PAD_W   = 16;
  localparam int DRIVE_W = 16;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CONFIG = 2'd0,
    OP_SET    = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_READ   = 2'd3
  } gpb_op_t;

  // pin mode codes that matter for configuration
  localparam logic [MODE_W-1:0] MODE_OUTPUT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALT    = 2'd2;

  // level codes for set
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // per-port configuration word
  typedef struct packed {
    logic [ALT_W*PINS_PER_PORT-1:0]   alt;
    logic [SPEED_W*PINS_PER_PORT-1:0] speed;
    logic [PINS_PER_PORT-1:0]         dtype;
    logic [PULL_W*PINS_PER_PORT-1:0]  pull;
    logic [MODE_W*PINS_PER_PORT-1:0]  mode;
  } gpb_cfg_t;

  localparam int CFG_W = $bits(gpb_cfg_t);

endpackage

### src/gpio_port_register_bank_core.sv
// ----------------------------------------------------------------------------
// gpio_port_register_bank_core
// GPIO port register bank with set/reset output semantics.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per pin operation:
//   configure, set level, toggle output or read pad. Result channel
//   (out_valid/out_ready) returns one word per input word: status, read bit
//   and the addressed port's output data word after the operation.
//   Port state sits in two RAMs (configuration word and output data word per
//   port), read at accept and written back when the word leaves the modify
//   stage. An accepted input word passes the modify stage, then the output
//   register, before its result is shown.
//   Throughput: one word per cycle while out_ready is high; the
//   read-modify-write loop closes through a forwarding register, so
//   back-to-back words to the same port see the previous write.
//   Reset: a per-port valid bit is cleared, so every port reads as all zero
//   until first written; no clearing pass is needed.
//   Stall: when out_ready is low the result holds, one more word is held in
//   the modify stage, and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module gpio_port_register_bank_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gpb_pkg::OP_W-1:0]     in_op,
  input  logic [gpb_pkg::PORT_W-1:0]   in_port_sel,
  input  logic [gpb_pkg::PIN_W-1:0]    in_pin_sel,
  input  logic [gpb_pkg::MODE_W-1:0]   in_pin_mode,
  input  logic [gpb_pkg::PULL_W-1:0]   in_pull_sel,
  input  logic                         in_open_drain,
  input  logic [gpb_pkg::SPEED_W-1:0]  in_slew_speed,
  input  logic [gpb_pkg::ALT_W-1:0]    in_alt_function,
  input  logic [gpb_pkg::LEVEL_W-1:0]  in_level,
  input  logic [gpb_pkg::PAD_W-1:0]    in_pad_levels,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic                         out_read_bit,
  output logic [gpb_pkg::DRIVE_W-1:0]  out_port_drive
);
  import gpb_pkg::*;

  // handshake
  logic in_fire;
  logic out_go;
  logic s2_done;

  // modify stage
  logic                    s2_valid_r;
  gpb_op_t                 s2_op_r;
  logic [PORT_W-1:0]       s2_port_r;
  logic [PIN_W-1:0]        s2_pin_r;
  logic [MODE_W-1:0]       s2_mode_r;
  logic [PULL_W-1:0]       s2_pull_r;
  logic                    s2_od_r;
  logic [SPEED_W-1:0]      s2_speed_r;
  logic [ALT_W-1:0]        s2_alt_r;
  logic [LEVEL_W-1:0]      s2_level_r;
  logic [PAD_W-1:0]        s2_pads_r;

  // memory interface
  logic [PORT_AW-1:0]       rd_addr;
  logic [PORT_AW-1:0]       wr_addr;
  logic                     wr_en;
  gpb_cfg_t                 cfg_rdata;
  logic [PINS_PER_PORT-1:0] drv_rdata;
  logic [NUM_PORTS-1:0]     port_vld_r;
  logic                     rd_vld_r;

  // forwarding of the last write
  logic                     fwd_r;
  gpb_cfg_t                 fwd_cfg_r;
  logic [PINS_PER_PORT-1:0] fwd_drv_r;

  // modify logic
  gpb_cfg_t                 cur_cfg;
  logic [PINS_PER_PORT-1:0] cur_drv;
  gpb_cfg_t                 cfg_nxt;
  logic [PINS_PER_PORT-1:0] drv_nxt;
  logic                     port_ok;
  logic                     pin_ok;
  logic                     is_out_mode;
  logic                     is_alt_mode;
  logic                     status_nxt;
  logic                     rbit_nxt;
  logic [DRIVE_W-1:0]       drive_nxt;

  // output register
  logic                     out_valid_r;
  logic                     out_status_r;
  logic                     out_read_bit_r;
  logic [DRIVE_W-1:0]       out_port_drive_r;

  assign out_go   = !out_valid_r || out_ready;
  assign in_ready = !s2_valid_r || out_go;
  assign in_fire  = in_valid && in_ready;
  assign s2_done  = s2_valid_r && out_go;

  // modify stage control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_ready) begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_op_r    <= gpb_op_t'(in_op);
      s2_port_r  <= in_port_sel;
      s2_pin_r   <= in_pin_sel;
      s2_mode_r  <= in_pin_mode;
      s2_pull_r  <= in_pull_sel;
      s2_od_r    <= in_open_drain;
      s2_speed_r <= in_slew_speed;
      s2_alt_r   <= in_alt_function;
      s2_level_r <= in_level;
      s2_pads_r  <= in_pad_levels;
    end
  end

  // address range checks
  assign port_ok = ({2'b00, s2_port_r} < 5'(NUM_PORTS));
  assign pin_ok  = ({1'b0, s2_pin_r} < 5'(PINS_PER_PORT));

  assign rd_addr = in_port_sel[PORT_AW-1:0];
  assign wr_addr = s2_port_r[PORT_AW-1:0];
  assign wr_en   = s2_done && port_ok && pin_ok;

  // per-port state memories
  gpb_ram #(
    .WIDTH (CFG_W),
    .DEPTH (NUM_PORTS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cfg_nxt),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (cfg_rdata)
  );

  gpb_ram #(
    .WIDTH (PINS_PER_PORT),
    .DEPTH (NUM_PORTS)
  ) u_drv_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (drv_nxt),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (drv_rdata)
  );

  // written-once flags stand in for the zero reset of the memories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (wr_en) begin
        port_vld_r[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_r <= port_vld_r[rd_addr];
        fwd_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_cfg_r <= cfg_nxt;
      fwd_drv_r <= drv_nxt;
    end
  end

  // current port words: forwarded, stored or reset value
  always_comb begin
    if (fwd_r) begin
      cur_cfg = fwd_cfg_r;
      cur_drv = fwd_drv_r;
    end else if (rd_vld_r) begin
      cur_cfg = cfg_rdata;
      cur_drv = drv_rdata;
    end else begin
      cur_cfg = '0;
      cur_drv = '0;
    end
  end

  assign is_out_mode = (s2_mode_r == MODE_OUTPUT) || (s2_mode_r == MODE_ALT);
  assign is_alt_mode = (s2_mode_r == MODE_ALT);

  // read-modify-write of the addressed pin
  always_comb begin
    cfg_nxt    = cur_cfg;
    drv_nxt    = cur_drv;
    status_nxt = STATUS_OK;
    rbit_nxt   = 1'b0;
    unique case (s2_op_r)
      OP_CONFIG: begin
        for (int i = 0; i < PINS_PER_PORT; i++) begin
          if (PIN_W'(i) == s2_pin_r) begin
            cfg_nxt.mode[MODE_W*i +: MODE_W] = s2_mode_r;
            cfg_nxt.pull[PULL_W*i +: PULL_W] = s2_pull_r;
            if (is_out_mode) begin
              cfg_nxt.dtype[i]                   = s2_od_r;
              cfg_nxt.speed[SPEED_W*i +: SPEED_W] = s2_speed_r;
            end
            if (is_alt_mode) begin
              cfg_nxt.alt[ALT_W*i +: ALT_W] = s2_alt_r;
            end
          end
        end
      end
      OP_SET: begin
        for (int i = 0; i < PINS_PER_PORT; i++) begin
          if (PIN_W'(i) == s2_pin_r) begin
            if (s2_level_r == LEVEL_LOW) begin
              drv_nxt[i] = 1'b0;
            end else if (s2_level_r == LEVEL_HIGH) begin
              drv_nxt[i] = 1'b1;
            end
          end
        end
        if ((s2_level_r != LEVEL_LOW) && (s2_level_r != LEVEL_HIGH)) begin
          status_nxt = STATUS_ERR;
        end
      end
      OP_TOGGLE: begin
        for (int i = 0; i < PINS_PER_PORT; i++) begin
          if (PIN_W'(i) == s2_pin_r) begin
            drv_nxt[i] = !cur_drv[i];
          end
        end
      end
      OP_READ: begin
        rbit_nxt = s2_pads_r[s2_pin_r];
      end
      default: begin
        status_nxt = STATUS_ERR;
      end
    endcase

    // out-of-range addresses change nothing
    if (!port_ok) begin
      status_nxt = STATUS_ERR;
      rbit_nxt   = 1'b0;
    end else if (!pin_ok) begin
      status_nxt = STATUS_ERR;
      rbit_nxt   = 1'b0;
    end
  end

  // port drive word reported after the step
  always_comb begin
    if (!port_ok) begin
      drive_nxt = '0;
    end else if (!pin_ok) begin
      drive_nxt = DRIVE_W'(cur_drv);
    end else begin
      drive_nxt = DRIVE_W'(drv_nxt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_go) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      out_status_r     <= status_nxt;
      out_read_bit_r   <= rbit_nxt;
      out_port_drive_r <= drive_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_bit   = out_read_bit_r;
  assign out_port_drive = out_port_drive_r;

endmodule

### src/gpb_ram.sv
// ----------------------------------------------------------------------------
// gpb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/gpb_checker.sv
// ----------------------------------------------------------------------------
// gpb_checker
// Port-level checks for the gpio port register bank, bound to the top level.
// ----------------------------------------------------------------------------
module gpb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic                         out_read_bit,
  input logic [gpb_pkg::DRIVE_W-1:0]  out_port_drive
);
  import gpb_pkg::*;

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_port_drive)
      && $stable(out_status) && $stable(out_read_bit)))
    else $error("stalled result word changed");

  // input backpressure only when the result side is stalled
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result side is free");

  // an error never comes with a read bit
  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_ERR)) |-> !out_read_bit)
    else $error("read bit set on an error result");

endmodule

bind gpio_port_register_bank_core gpb_checker u_gpb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_read_bit   (out_read_bit),
  .out_port_drive (out_port_drive)
);
